/* rtl/core/ktrd_pkg.sv */
package ktrd_pkg;

	// default and largest supported ranking length
	localparam int MAX_ITEMS_DEF = 64;
	localparam int MAX_ITEMS_TOP = 1024;

	// field widths
	localparam int RANK_W = 8;
	localparam int DIST_W = 11;
	localparam int IDX_W  = $clog2(MAX_ITEMS_TOP + 1);

	// saturation limit of the distance
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// input word
	typedef struct packed {
		logic [RANK_W-1:0] rank_first;
		logic [RANK_W-1:0] rank_second;
		logic              last_item;
	} in_word_t;

	// output word
	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} out_word_t;

	// word traveling down the chain of cells
	typedef struct packed {
		logic [RANK_W-1:0] rank_first;
		logic [RANK_W-1:0] rank_second;
		logic              last_item;
		logic              spill;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] add;
	} cell_word_t;

endpackage

/* rtl/core/ktrd_cell.sv */
module ktrd_cell #(
	parameter int POS = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                prev_valid,
	input  ktrd_pkg::cell_word_t prev_word,
	output logic                valid_s1,
	output ktrd_pkg::cell_word_t word_s1
);

	logic [ktrd_pkg::RANK_W-1:0] stored_first_q;
	logic [ktrd_pkg::RANK_W-1:0] stored_second_q;
	logic                        hit;
	logic                        capture;
	logic                        discordant;
	ktrd_pkg::cell_word_t        next_word;

	// compare against the held pair when the word comes later in the ranking
	always_comb begin
		hit = prev_valid && !prev_word.spill &&
			(prev_word.idx > ktrd_pkg::IDX_W'(POS));
		capture = advance && prev_valid && !prev_word.spill &&
			(prev_word.idx == ktrd_pkg::IDX_W'(POS));
		discordant = ((stored_first_q > prev_word.rank_first) &&
				(stored_second_q < prev_word.rank_second)) ||
			((stored_first_q < prev_word.rank_first) &&
				(stored_second_q > prev_word.rank_second));
		next_word = prev_word;
		if (hit && discordant) begin
			next_word.add = prev_word.add + ktrd_pkg::DIST_W'(1);
		end
	end

	// held pair of this position
	always_ff @(posedge clk) begin
		if (capture) begin
			stored_first_q  <= prev_word.rank_first;
			stored_second_q <= prev_word.rank_second;
		end
	end

	// hand the word to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			word_s1 <= next_word;
		end
	end

endmodule

/* rtl/core/ktrd_tail.sv */
module ktrd_tail (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 chain_valid,
	input  ktrd_pkg::cell_word_t chain_word,
	output logic                 result_valid_q,
	output ktrd_pkg::out_word_t  result_q
);

	logic [ktrd_pkg::DIST_W-1:0] sum_q;
	logic                        ovf_q;
	logic [ktrd_pkg::DIST_W:0]   wide_sum;
	logic [ktrd_pkg::DIST_W-1:0] sat_sum;
	logic                        ovf_next;

	// saturating running total
	always_comb begin
		wide_sum = {1'b0, sum_q} + {1'b0, chain_word.add};
		if (wide_sum[ktrd_pkg::DIST_W]) begin
			sat_sum = ktrd_pkg::DIST_MAX;
		end else begin
			sat_sum = wide_sum[ktrd_pkg::DIST_W-1:0];
		end
		ovf_next = ovf_q | chain_word.spill;
	end

	// accumulate, emit and restart on the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q          <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= chain_valid && chain_word.last_item;
			if (chain_valid) begin
				if (chain_word.last_item) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sat_sum;
					ovf_q <= ovf_next;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && chain_valid && chain_word.last_item) begin
			result_q.distance <= sat_sum;
			result_q.overflow <= ovf_next;
		end
	end

endmodule

/* rtl/core/kendall_tau_rank_distance.sv */
// Kendall tau rank distance over a stream of rank pairs.
// Input channel (sample_valid, sample_stall, sample): one word per element,
// its rank in the first and in the second ranking plus a last flag.
// Output channel (result_valid, result_stall, result): one word per ranking,
// sent for the element marked last, with the count of discordant pairs and
// a flag set when more than MAX_ITEMS elements arrived (extras are ignored).
// Elements enter a row of MAX_ITEMS cells; each cell keeps one element of the
// current ranking and checks every later element against it as it passes.
// One element is taken per cycle while sample_stall is low. The result is
// registered in the tail once its last element has passed every cell of the row.
// Rankings follow each other with no gap.
// Reset clears the element counter, the running total and all valid stages;
// stored ranks need no clearing since a cell only compares elements that come
// after the one it captured in the same ranking.
// While result_stall holds a waiting result, the whole row freezes and
// sample_stall is raised in the same cycle.
module kendall_tau_rank_distance #(
	parameter int MAX_ITEMS = ktrd_pkg::MAX_ITEMS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  ktrd_pkg::in_word_t  sample,
	output logic                result_valid,
	input  logic                result_stall,
	output ktrd_pkg::out_word_t result
);

	logic                        advance;
	logic [ktrd_pkg::IDX_W-1:0]  count_q;
	logic                        full;
	ktrd_pkg::cell_word_t        entry_word;
	logic                        chain_valid [MAX_ITEMS+1];
	ktrd_pkg::cell_word_t        chain_word  [MAX_ITEMS+1];

	// the row moves unless a finished result is held back
	assign advance      = !(result_valid && result_stall);
	assign sample_stall = !advance;

	// position of the next element within its ranking
	assign full = (count_q == ktrd_pkg::IDX_W'(MAX_ITEMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (advance && sample_valid) begin
			if (sample.last_item) begin
				count_q <= '0;
			end else if (!full) begin
				count_q <= count_q + ktrd_pkg::IDX_W'(1);
			end
		end
	end

	// word entering the row
	always_comb begin
		entry_word.rank_first  = sample.rank_first;
		entry_word.rank_second = sample.rank_second;
		entry_word.last_item   = sample.last_item;
		entry_word.spill       = full;
		entry_word.idx         = count_q;
		entry_word.add         = '0;
	end

	assign chain_valid[0] = sample_valid;
	assign chain_word[0]  = entry_word;

	// row of cells, one per stored element
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		ktrd_cell #(
			.POS(g)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.prev_valid(chain_valid[g]),
			.prev_word (chain_word[g]),
			.valid_s1  (chain_valid[g+1]),
			.word_s1   (chain_word[g+1])
		);
	end

	// totals and result register
	ktrd_tail u_tail (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.chain_valid   (chain_valid[MAX_ITEMS]),
		.chain_word    (chain_word[MAX_ITEMS]),
		.result_valid_q(result_valid),
		.result_q      (result)
	);

endmodule
